// ===== rtl/krpec_pkg.sv =====
// ============================================================================
// krpec_pkg
// Shared types and constants for the keyed runtime profile EWMA cache.
// ============================================================================
package krpec_pkg;

    // Field widths of one transaction.
    localparam int KEY_W   = 32;
    localparam int RUN_W   = 32;
    localparam int TOT_W   = 64;
    localparam int CYC_W   = 32;
    localparam int SEEN_W  = 16;
    localparam int SMP_W   = 16;
    localparam int CONF_W  = 7;
    localparam int SHIFT_W = 5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_KEY = 2'd1,
        ST_NO_SLOT  = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic REG_EWMA_SHIFT = 1'b0;
    localparam logic [SHIFT_W-1:0] EWMA_SHIFT_RESET = 5'd3;

    // Confidence scale.
    localparam logic [CONF_W-1:0] CONF_BASE = 7'd20;
    localparam logic [CONF_W-1:0] CONF_STEP = 7'd10;
    localparam logic [CONF_W-1:0] CONF_MAX  = 7'd80;
    localparam int CONF_SAT_SAMPLES = (80 - 20) / 10;

    // Bit-serial divider: one quotient bit per cycle.
    localparam int DIV_STEPS = TOT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Per-slot statistics held in the data memory.
    typedef struct packed {
        logic [TOT_W-1:0]  seen_cycles;
        logic [SEEN_W-1:0] seen_count;
        logic [SMP_W-1:0]  samples;
        logic [CYC_W-1:0]  avg_cycles;
    } slot_data_t;

endpackage

// ===== rtl/krpec_div.sv =====
// ============================================================================
// krpec_div
// Restoring bit-serial divider, 64-bit dividend by 16-bit nonzero divisor.
// ============================================================================
module krpec_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [krpec_pkg::TOT_W-1:0]       dividend,
    input  logic [krpec_pkg::SEEN_W-1:0]      divisor,
    output logic                              done,
    output logic [krpec_pkg::TOT_W-1:0]       quotient
);

    logic                              run_reg;
    logic [krpec_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                              done_reg;
    logic [krpec_pkg::TOT_W-1:0]       dq_reg;
    logic [krpec_pkg::SEEN_W-1:0]      rem_reg;
    logic [krpec_pkg::SEEN_W-1:0]      dvs_reg;
    logic [krpec_pkg::SEEN_W:0]        trial;
    logic                              fits;

    assign trial = {rem_reg, dq_reg[krpec_pkg::TOT_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && run_reg && (cnt_reg == krpec_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= krpec_pkg::DIV_CNT_W'(krpec_pkg::DIV_STEPS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == krpec_pkg::DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= krpec_pkg::SEEN_W'(trial - {1'b0, dvs_reg});
                dq_reg  <= {dq_reg[krpec_pkg::TOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[krpec_pkg::SEEN_W-1:0];
                dq_reg  <= {dq_reg[krpec_pkg::TOT_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== rtl/keyed_runtime_profile_ewma_cache.sv =====
// ============================================================================
// keyed_runtime_profile_ewma_cache
// Per-task runtime profile cache with a shift-based moving average.
// ============================================================================
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low. It carries a task key and that task's cumulative run count,
// cumulative cycle total and last run cycles. Exactly one result comes back
// on the result ports, marked by done for a single cycle; the receiver cannot
// stall, so the result must be captured in that cycle.
// A zero key is answered in the next cycle with busy staying low. Otherwise
// the block scans the key memory one slot per cycle up to the fill count,
// reads the slot's statistics, and, when both deltas are nonzero, runs a
// 64-step bit-serial divider. The divide and the slot scan, which grows with
// the fill count, set how long a transaction takes from acceptance to result;
// a key refused by a full table is answered after a scan of every slot.
// The ewma_shift register sits at byte address 0 of the APB port and must be
// written only while busy is low. Reset empties every slot at once by
// clearing the fill count; ewma_shift returns to 3.
// ============================================================================
module keyed_runtime_profile_ewma_cache
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [krpec_pkg::KEY_W-1:0]      task_key,
    input  logic [krpec_pkg::RUN_W-1:0]      run_count,
    input  logic [krpec_pkg::TOT_W-1:0]      cycle_total,
    input  logic [krpec_pkg::CYC_W-1:0]      last_run,
    // Result channel
    output logic                             done,
    output logic [1:0]                       status,
    output logic [krpec_pkg::CYC_W-1:0]      handler_estimate,
    output logic                             has_samples,
    output logic [krpec_pkg::SMP_W-1:0]      sample_total,
    output logic [krpec_pkg::CONF_W-1:0]     confidence,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FIL_W = $clog2(SLOT_COUNT + 1);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_RDDATA = 9'b000000100,
        S_PREP   = 9'b000001000,
        S_DELTA  = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_EWMA1  = 9'b001000000,
        S_EWMA2  = 9'b010000000,
        S_WRITE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Memories: slot keys and per-slot statistics. Entries at or above the
    // fill count were never claimed and are never trusted.
    logic [krpec_pkg::KEY_W-1:0] key_mem  [SLOT_COUNT];
    krpec_pkg::slot_data_t       data_mem [SLOT_COUNT];

    // Configuration.
    logic [krpec_pkg::SHIFT_W-1:0] ewma_shift_reg;
    logic                          cfg_wr;

    // Control.
    logic [FIL_W-1:0] fill_reg;
    logic [FIL_W-1:0] scan_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             new_reg;
    logic             done_reg;

    // Transaction payload.
    logic [krpec_pkg::KEY_W-1:0]  key_reg;
    logic [krpec_pkg::RUN_W-1:0]  cnt_reg;
    logic [krpec_pkg::TOT_W-1:0]  tot_reg;
    logic [krpec_pkg::CYC_W-1:0]  last_reg;

    // Working data.
    logic [krpec_pkg::KEY_W-1:0]  key_rd_reg;
    krpec_pkg::slot_data_t        data_rd_reg;
    krpec_pkg::slot_data_t        cur_reg;
    logic [krpec_pkg::SEEN_W-1:0] cdelta_reg;
    logic [krpec_pkg::CYC_W-1:0]  hc_reg;
    logic [krpec_pkg::CYC_W-1:0]  diff_reg;
    logic                         ge_reg;

    // Result registers.
    krpec_pkg::status_t            status_reg;
    logic [krpec_pkg::CYC_W-1:0]   hcyc_reg;
    logic                          has_reg;
    logic [krpec_pkg::SMP_W-1:0]   smp_reg;
    logic [krpec_pkg::CONF_W-1:0]  conf_reg;

    // Combinational helpers.
    logic                          accept;
    logic                          scan_more;
    logic                          hit;
    logic                          miss;
    logic                          table_full;
    krpec_pkg::slot_data_t         base_data;
    logic                          went_back;
    logic [krpec_pkg::TOT_W-1:0]   ydelta;
    logic [krpec_pkg::SEEN_W-1:0]  cdelta;
    logic                          do_div;
    logic                          div_done;
    logic [krpec_pkg::TOT_W-1:0]   div_q;
    logic [krpec_pkg::CYC_W-1:0]   q_sat;
    logic [krpec_pkg::CYC_W-1:0]   step;
    logic [krpec_pkg::CYC_W-1:0]   avg_new;
    logic [krpec_pkg::SMP_W:0]     smp_sum;
    logic [krpec_pkg::SMP_W-1:0]   smp_new;
    logic [krpec_pkg::CONF_W-1:0]  conf_calc;

    assign accept     = start && (state_reg == S_IDLE);
    assign scan_more  = (scan_reg < fill_reg);
    assign hit        = cmp_vld_reg && (key_rd_reg == key_reg);
    assign miss       = !cmp_vld_reg && !scan_more;
    assign table_full = (fill_reg == FIL_W'(SLOT_COUNT));

    // A newly claimed slot starts from the reset contents.
    assign base_data = new_reg ? '0 : data_rd_reg;
    assign went_back = (cnt_reg < {{(krpec_pkg::RUN_W-krpec_pkg::SEEN_W){1'b0}},
                                   base_data.seen_count})
                    || (tot_reg < base_data.seen_cycles);

    assign cdelta = cnt_reg[krpec_pkg::SEEN_W-1:0] - cur_reg.seen_count;
    assign ydelta = tot_reg - cur_reg.seen_cycles;
    assign do_div = (cdelta != '0) && (tot_reg != cur_reg.seen_cycles);

    assign q_sat = (div_q[krpec_pkg::TOT_W-1:krpec_pkg::CYC_W] != '0)
                 ? '1 : div_q[krpec_pkg::CYC_W-1:0];

    assign step    = diff_reg >> ewma_shift_reg;
    assign avg_new = (cur_reg.avg_cycles == '0) ? hc_reg
                   : (ge_reg ? cur_reg.avg_cycles + step : cur_reg.avg_cycles - step);

    assign smp_sum = {1'b0, cur_reg.samples} + {1'b0, cdelta_reg};
    assign smp_new = smp_sum[krpec_pkg::SMP_W] ? '1 : smp_sum[krpec_pkg::SMP_W-1:0];

    // Confidence grows by a fixed step per sample until it saturates.
    always_comb
    begin
        if (cur_reg.samples == '0)
            conf_calc = '0;
        else if (cur_reg.samples >= krpec_pkg::SMP_W'(krpec_pkg::CONF_SAT_SAMPLES))
            conf_calc = krpec_pkg::CONF_MAX;
        else
            conf_calc = krpec_pkg::CONF_BASE
                      + krpec_pkg::CONF_STEP * {4'b0, cur_reg.samples[2:0]};
    end

    krpec_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == S_DELTA) && do_div),
        .dividend (ydelta),
        .divisor  (cdelta),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (task_key != '0))
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (hit)
                    state_next = S_RDDATA;
                else if (miss)
                    state_next = table_full ? S_IDLE : S_RDDATA;
            end
            S_RDDATA: state_next = S_PREP;
            S_PREP:   state_next = S_DELTA;
            S_DELTA:  state_next = do_div ? S_DIV : S_WRITE;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_EWMA1;
            end
            S_EWMA1:  state_next = S_EWMA2;
            S_EWMA2:  state_next = S_WRITE;
            S_WRITE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            ewma_shift_reg <= krpec_pkg::EWMA_SHIFT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            // The strobe follows a zero key, a refusal, or the write-back.
            done_reg    <= (accept && (task_key == '0))
                        || ((state_reg == S_SEARCH) && miss && table_full)
                        || (state_reg == S_WRITE);
            cmp_vld_reg <= (state_reg == S_SEARCH) && scan_more && !hit;
            if (cfg_wr)
                ewma_shift_reg <= pwdata[krpec_pkg::SHIFT_W-1:0];
            if (accept)
            begin
                scan_reg <= '0;
            end
            if (state_reg == S_SEARCH)
            begin
                if (scan_more)
                    scan_reg <= scan_reg + 1'b1;
                if (!hit && miss && !table_full)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Key memory: read one slot per cycle during the scan, write on a claim.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEARCH) && scan_more)
            key_rd_reg <= key_mem[scan_reg[IDX_W-1:0]];
        if ((state_reg == S_SEARCH) && !hit && miss && !table_full)
            key_mem[fill_reg[IDX_W-1:0]] <= key_reg;
    end

    // Data memory: one read and one write-back per transaction that owns a slot.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RDDATA)
            data_rd_reg <= data_mem[slot_reg];
        if (state_reg == S_WRITE)
            data_mem[slot_reg] <= cur_reg;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_reg[IDX_W-1:0];
        if (accept)
        begin
            key_reg  <= task_key;
            cnt_reg  <= run_count;
            tot_reg  <= cycle_total;
            last_reg <= last_run;
            if (task_key == '0)
            begin
                status_reg <= krpec_pkg::ST_ZERO_KEY;
                hcyc_reg   <= '0;
                has_reg    <= 1'b0;
                smp_reg    <= '0;
                conf_reg   <= '0;
            end
        end
        case (state_reg)
            S_SEARCH:
            begin
                if (hit)
                begin
                    slot_reg <= cmp_idx_reg;
                    new_reg  <= 1'b0;
                end
                else if (miss)
                begin
                    slot_reg <= fill_reg[IDX_W-1:0];
                    new_reg  <= 1'b1;
                    if (table_full)
                    begin
                        status_reg <= krpec_pkg::ST_NO_SLOT;
                        hcyc_reg   <= '0;
                        has_reg    <= 1'b0;
                        smp_reg    <= '0;
                        conf_reg   <= '0;
                    end
                end
            end
            S_PREP:
            begin
                // A counter that went backwards restarts the slot's history.
                cur_reg <= went_back ? '0 : base_data;
            end
            S_DELTA:
            begin
                cdelta_reg <= cdelta;
            end
            S_DIV:
            begin
                if (div_done)
                    hc_reg <= q_sat;
            end
            S_EWMA1:
            begin
                ge_reg   <= (hc_reg >= cur_reg.avg_cycles);
                diff_reg <= (hc_reg >= cur_reg.avg_cycles) ? hc_reg - cur_reg.avg_cycles
                                                           : cur_reg.avg_cycles - hc_reg;
            end
            S_EWMA2:
            begin
                cur_reg.avg_cycles  <= avg_new;
                cur_reg.samples     <= smp_new;
                cur_reg.seen_cycles <= tot_reg;
                cur_reg.seen_count  <= cnt_reg[krpec_pkg::SEEN_W-1:0];
            end
            S_WRITE:
            begin
                status_reg <= krpec_pkg::ST_OK;
                hcyc_reg   <= (last_reg > cur_reg.avg_cycles) ? last_reg
                                                              : cur_reg.avg_cycles;
                has_reg    <= (cur_reg.samples != '0);
                smp_reg    <= cur_reg.samples;
                conf_reg   <= conf_calc;
            end
            default:
            begin
            end
        endcase
    end

    // APB register access.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == krpec_pkg::REG_EWMA_SHIFT);
    assign prdata = (paddr[2] == krpec_pkg::REG_EWMA_SHIFT)
                  ? {{(32-krpec_pkg::SHIFT_W){1'b0}}, ewma_shift_reg} : '0;
    assign pready = 1'b1;

    // Outputs.
    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign handler_estimate = hcyc_reg;
    assign has_samples      = has_reg;
    assign sample_total     = smp_reg;
    assign confidence       = conf_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the keyed runtime profile EWMA cache.
// ============================================================================
// A short table of directed transactions covers the zero key, a full table,
// quotient saturation, 16-bit run wrap, counters that go backwards and
// sample saturation. A long random run follows, made mostly of well-formed
// per-task counter sequences. Every accepted transaction is folded into a
// private model of the slot table, and each strobed result is compared
// field by field with the oldest outstanding prediction. The ewma_shift
// register is rewritten between phases while the block is idle.
// ============================================================================
module tb;

    import krpec_pkg::*;

    localparam int SLOTS = 8;
    localparam int PHASE_ITEMS = 316;
    localparam logic [2:0] SHIFT_ADDR = {REG_EWMA_SHIFT, 2'b00};

    // One command transaction as driven onto the ports.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [RUN_W-1:0] runs;
        logic [TOT_W-1:0] total;
        logic [CYC_W-1:0] last;
    } probe_t;

    // One result transaction as seen on the result ports.
    typedef struct packed {
        status_t           status;
        logic [CYC_W-1:0]  handler;
        logic              has;
        logic [SMP_W-1:0]  samples;
        logic [CONF_W-1:0] conf;
    } profile_t;

    // A row of the directed table. Rows with typed set carry an expectation
    // that is obvious by inspection; all other rows rely on the model.
    typedef struct {
        probe_t   p;
        bit       typed;
        profile_t want;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [KEY_W-1:0]  task_key;
    logic [RUN_W-1:0]  run_count;
    logic [TOT_W-1:0]  cycle_total;
    logic [CYC_W-1:0]  last_run;
    logic              done;
    logic [1:0]        status;
    logic [CYC_W-1:0]  handler_estimate;
    logic              has_samples;
    logic [SMP_W-1:0]  sample_total;
    logic [CONF_W-1:0] confidence;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Private copy of the slot table and of the shift register.
    logic [KEY_W-1:0]   slot_key_tab   [SLOTS];
    logic [TOT_W-1:0]   slot_seen_total[SLOTS];
    logic [SEEN_W-1:0]  slot_seen_runs [SLOTS];
    logic [SMP_W-1:0]   slot_samples   [SLOTS];
    logic [CYC_W-1:0]   slot_avg       [SLOTS];
    logic [SHIFT_W-1:0] cur_shift;

    // Results predicted for accepted transactions, oldest first.
    profile_t pending_profiles[$];
    int unsigned mismatches;

    // Task keys used by the stimulus and the counters each task has reported.
    logic [KEY_W-1:0] pool_key   [SLOTS];
    logic [RUN_W-1:0] track_runs [SLOTS];
    logic [TOT_W-1:0] track_total[SLOTS];

    row_t directed_rows[$];

    keyed_runtime_profile_ewma_cache
    #(
        .SLOT_COUNT(SLOTS)
    )
    i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .task_key(task_key),
        .run_count(run_count),
        .cycle_total(cycle_total),
        .last_run(last_run),
        .done(done),
        .status(status),
        .handler_estimate(handler_estimate),
        .has_samples(has_samples),
        .sample_total(sample_total),
        .confidence(confidence),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Generous ceiling: the slowest legal run, with every transaction going
    // through the divider and the sender's longest gaps, is under 5 ms.
    initial
    begin
        #(64'd20_000_000);
        $display("status: fail");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Folds one accepted transaction into the private slot table and returns
    // the result the block must report for it.
    function automatic profile_t fold_profile(probe_t p);
        profile_t r;
        int slot;
        int free_at;
        int i;
        int unsigned smp;
        int unsigned c;
        logic [SEEN_W-1:0] run_delta;
        logic [TOT_W-1:0]  cyc_delta;
        logic [TOT_W-1:0]  quo;
        logic [CYC_W-1:0]  per_run;
        logic [CYC_W-1:0]  avg;
        r = '0;
        r.status = ST_OK;
        if (p.key == '0)
        begin
            r.status = ST_ZERO_KEY;
            return r;
        end
        // The key's own slot wins; otherwise the lowest free slot is claimed.
        slot = -1;
        free_at = -1;
        for (i = 0; i < SLOTS; i++)
        begin
            if (slot < 0 && slot_key_tab[i] == p.key)
                slot = i;
            if (free_at < 0 && slot_key_tab[i] == '0)
                free_at = i;
        end
        if (slot < 0 && free_at >= 0)
        begin
            slot = free_at;
            slot_key_tab[slot] = p.key;
        end
        if (slot < 0)
        begin
            r.status = ST_NO_SLOT;
            return r;
        end
        // A counter that moved backwards means the task restarted.
        if (p.runs < {16'd0, slot_seen_runs[slot]} || p.total < slot_seen_total[slot])
        begin
            slot_seen_total[slot] = '0;
            slot_seen_runs[slot]  = '0;
            slot_samples[slot]    = '0;
            slot_avg[slot]        = '0;
        end
        run_delta = p.runs[SEEN_W-1:0] - slot_seen_runs[slot];
        cyc_delta = p.total - slot_seen_total[slot];
        if (run_delta != '0 && cyc_delta != '0)
        begin
            quo = cyc_delta / {48'd0, run_delta};
            per_run = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[CYC_W-1:0];
            avg = slot_avg[slot];
            if (avg == '0)
                avg = per_run;
            else if (per_run >= avg)
                avg = avg + ((per_run - avg) >> cur_shift);
            else
                avg = avg - ((avg - per_run) >> cur_shift);
            slot_avg[slot] = avg;
            smp = int'(slot_samples[slot]) + int'(run_delta);
            slot_samples[slot]    = (smp > 65535) ? 16'hFFFF : smp[SMP_W-1:0];
            slot_seen_total[slot] = p.total;
            slot_seen_runs[slot]  = p.runs[SEEN_W-1:0];
        end
        r.handler = (p.last > slot_avg[slot]) ? p.last : slot_avg[slot];
        r.samples = slot_samples[slot];
        r.has = (slot_samples[slot] != '0);
        if (r.has)
        begin
            c = int'(CONF_BASE) + int'(CONF_STEP) * int'(slot_samples[slot]);
            r.conf = (c > int'(CONF_MAX)) ? CONF_MAX : c[CONF_W-1:0];
        end
        return r;
    endfunction

    // A random nonzero key that no tracked task uses, so it never owns a slot.
    function automatic logic [KEY_W-1:0] stranger_key();
        logic [KEY_W-1:0] k;
        bit clash;
        int i;
        do
        begin
            k = $urandom;
            clash = (k == '0);
            for (i = 0; i < SLOTS; i++)
                if (pool_key[i] == k)
                    clash = 1'b1;
        end
        while (clash);
        return k;
    endfunction

    // Most gaps are short, a few are long enough to cover the whole divide.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    task automatic add_row(input logic [KEY_W-1:0] key, input logic [RUN_W-1:0] runs,
                           input logic [TOT_W-1:0] total, input logic [CYC_W-1:0] last,
                           input bit typed, input profile_t want);
        row_t row;
        row.p = '{key, runs, total, last};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // Drives one transaction from a falling edge and holds it until the block
    // takes it. Returns at the falling edge after acceptance with start still
    // high, so that a back-to-back transaction does not drop it.
    task automatic send_probe(input probe_t p, input bit typed, input profile_t want);
        profile_t predicted;
        start       = 1'b1;
        task_key    = p.key;
        run_count   = p.runs;
        cycle_total = p.total;
        last_run    = p.last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // The model is always updated so that later rows stay in step.
        predicted = fold_profile(p);
        pending_profiles.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start = 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Lowers start and waits until every predicted result has arrived.
    task automatic wait_drained();
        start = 1'b0;
        @(posedge clk);
        while (pending_profiles.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = SHIFT_ADDR;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_shift_readback(input logic [SHIFT_W-1:0] want);
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        if (rd !== {27'd0, want})
            flag_mismatch($sformatf("ewma_shift read %0h want %0h", rd, want));
    endtask

    // Register writes happen only with the block idle. The upper data bits
    // are random; only the low five bits belong to the register.
    task automatic set_shift(input logic [SHIFT_W-1:0] sh);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, {27'($urandom_range(0, 32'h7FF_FFFF)), 5'd0} | {27'd0, sh}, rd);
        cur_shift = sh;
        check_shift_readback(sh);
    endtask

    // Builds the next random transaction. Most are well-formed steps of a
    // tracked task's counters; the rest are zero keys, strangers, noise and
    // restarts.
    function automatic probe_t next_probe();
        probe_t p;
        int idx;
        int roll;
        int pick;
        logic [RUN_W-1:0] dr;
        logic [TOT_W-1:0] dc;
        idx  = $urandom_range(0, SLOTS - 1);
        roll = $urandom_range(0, 99);
        p.last = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6000) : $urandom;
        if (roll < 5)
        begin
            p.key   = '0;
            p.runs  = $urandom;
            p.total = {$urandom, $urandom};
        end
        else if (roll < 10)
        begin
            p.key   = stranger_key();
            p.runs  = $urandom;
            p.total = {$urandom, $urandom};
        end
        else if (roll < 18)
        begin
            // Noise: arbitrary counters, which the task then continues from.
            track_runs[idx]  = $urandom;
            track_total[idx] = {$urandom, $urandom} >> $urandom_range(0, 40);
            p.key   = pool_key[idx];
            p.runs  = track_runs[idx];
            p.total = track_total[idx];
        end
        else if (roll < 23)
        begin
            // Restart: one of the two counters falls back.
            if ($urandom_range(0, 1))
                track_runs[idx] = $urandom_range(0, track_runs[idx]);
            else
                track_total[idx] = track_total[idx] >> $urandom_range(1, 8);
            p.key   = pool_key[idx];
            p.runs  = track_runs[idx];
            p.total = track_total[idx];
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                dr = '0;
            else if (pick < 15)
                dr = $urandom_range(1000, 70000);
            else
                dr = $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                dc = '0;
            else if (pick < 14)
                dc = {$urandom, $urandom} >> $urandom_range(0, 20);
            else
                dc = 64'(dr + 1) * 64'($urandom_range(1, 5000)) + 64'($urandom_range(0, 99));
            track_runs[idx]  = track_runs[idx] + dr;
            track_total[idx] = track_total[idx] + dc;
            p.key   = pool_key[idx];
            p.runs  = track_runs[idx];
            p.total = track_total[idx];
        end
        return p;
    endfunction

    // Result checker. Results cannot be held off, so each strobe is taken at
    // the rising edge that ends its cycle and matched against the oldest
    // prediction.
    always @(posedge clk)
    begin
        profile_t want;
        if (rst_n && done)
        begin
            if (pending_profiles.size() == 0)
            begin
                flag_mismatch("result strobe with no transaction outstanding");
            end
            else
            begin
                want = pending_profiles.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
                if (handler_estimate !== want.handler)
                    flag_mismatch($sformatf("handler_estimate got %0h want %0h",
                                            handler_estimate, want.handler));
                if (has_samples !== want.has)
                    flag_mismatch($sformatf("has_samples got %0b want %0b",
                                            has_samples, want.has));
                if (sample_total !== want.samples)
                    flag_mismatch($sformatf("sample_total got %0d want %0d",
                                            sample_total, want.samples));
                if (confidence !== want.conf)
                    flag_mismatch($sformatf("confidence got %0d want %0d",
                                            confidence, want.conf));
            end
        end
    end

    initial
    begin
        logic [SHIFT_W-1:0] phase_shift[6];
        profile_t none;
        bit burst;
        int i;
        int n;
        int ph;

        mismatches   = 0;
        none         = '0;
        rst_n        = 1'b0;
        start        = 1'b0;
        task_key     = '0;
        run_count    = '0;
        cycle_total  = '0;
        last_run     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        for (i = 0; i < SLOTS; i++)
        begin
            slot_key_tab[i]    = '0;
            slot_seen_total[i] = '0;
            slot_seen_runs[i]  = '0;
            slot_samples[i]    = '0;
            slot_avg[i]        = '0;
            track_runs[i]      = '0;
            track_total[i]     = '0;
        end
        cur_shift = EWMA_SHIFT_RESET;

        // Tracked keys: both key extremes, then distinct random keys.
        pool_key[0] = 32'h0000_0001;
        pool_key[1] = 32'hFFFF_FFFF;
        for (i = 2; i < SLOTS; i++)
        begin
            pool_key[i] = '0;
            pool_key[i] = stranger_key();
            if (pool_key[i] == 32'h8000_0000)
                pool_key[i] = 32'h8000_0001;
        end

        // Zero key with every other field at its maximum.
        add_row('0, '1, '1, '1, 1'b1, '{ST_ZERO_KEY, 32'd0, 1'b0, 16'd0, 7'd0});
        // First sight of a task with both counters at zero: nothing to fold.
        add_row(pool_key[0], 32'd0, 64'd0, 32'd0, 1'b1, '{ST_OK, 32'd0, 1'b0, 16'd0, 7'd0});
        // First sample seeds the average directly.
        add_row(pool_key[0], 32'd1, 64'd100, 32'd50, 1'b1,
                '{ST_OK, 32'd100, 1'b1, 16'd1, 7'd30});
        // Same per-run cost; last run dominates the reported figure.
        add_row(pool_key[0], 32'd3, 64'd300, 32'd500, 1'b1,
                '{ST_OK, 32'd500, 1'b1, 16'd3, 7'd50});
        // No new runs: the slot is reported unchanged; the next row folds in the cycles held back.
        add_row(pool_key[0], 32'd3, 64'd400, 32'd7, 1'b0, none);
        add_row(pool_key[0], 32'd4, 64'd400, 32'd7, 1'b0, none);
        // Enough samples to cap confidence.
        add_row(pool_key[0], 32'd10, 64'd1000, 32'd0, 1'b0, none);
        // Run count went backwards, then total went backwards.
        add_row(pool_key[0], 32'd2, 64'd2000, 32'd0, 1'b0, none);
        add_row(pool_key[0], 32'd5, 64'd10, 32'd0, 1'b0, none);
        // Quotient above 32 bits saturates.
        add_row(pool_key[1], 32'd1, '1, 32'd0, 1'b1,
                '{ST_OK, 32'hFFFF_FFFF, 1'b1, 16'd1, 7'd30});
        add_row(pool_key[1], '1, '1, 32'd0, 1'b0, none);
        // Run delta that is zero modulo 2^16, a full 16-bit delta that
        // saturates the sample count, and a delta across the 16-bit wrap.
        add_row(pool_key[2], 32'h0001_0000, 64'd5, 32'd3, 1'b0, none);
        add_row(pool_key[2], 32'h0001_FFFF, 64'd458750, 32'd3, 1'b0, none);
        add_row(pool_key[2], 32'h0002_0005, 64'd458810, 32'd3, 1'b0, none);
        // Fill the remaining slots.
        for (i = 3; i < SLOTS; i++)
            add_row(pool_key[i], 32'd2, 64'(2468 * i), 32'(i * 1000), 1'b0, none);
        // Table full: unknown keys are refused.
        add_row(stranger_key(), $urandom, {$urandom, $urandom}, $urandom, 1'b1,
                '{ST_NO_SLOT, 32'd0, 1'b0, 16'd0, 7'd0});
        add_row(32'h8000_0000, '1, '1, '1, 1'b1,
                '{ST_NO_SLOT, 32'd0, 1'b0, 16'd0, 7'd0});
        // Largest last run wins over any average.
        add_row(pool_key[0], 32'd5, 64'd10, '1, 1'b0, none);

        // Continue the tracked counters from where the table left them.
        track_runs[0]  = 32'd5;
        track_total[0] = 64'd10;
        track_runs[1]  = '1;
        track_total[1] = '1;
        track_runs[2]  = 32'h0002_0005;
        track_total[2] = 64'd458810;
        for (i = 3; i < SLOTS; i++)
        begin
            track_runs[i]  = 32'd2;
            track_total[i] = 64'(2468 * i);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        check_shift_readback(EWMA_SHIFT_RESET);

        // Directed table at the reset shift.
        foreach (directed_rows[k])
        begin
            send_probe(directed_rows[k].p, directed_rows[k].typed, directed_rows[k].want);
            idle_for(pick_gap());
        end

        // Random phases, each under its own shift: both extremes, the reset
        // value, small shifts and random ones.
        phase_shift[0] = 5'd0;
        phase_shift[1] = 5'd31;
        phase_shift[2] = 5'd1;
        phase_shift[3] = 5'($urandom_range(2, 30));
        phase_shift[4] = 5'd3;
        phase_shift[5] = 5'($urandom_range(0, 31));
        burst = 1'b0;
        for (ph = 0; ph < 6; ph++)
        begin
            set_shift(phase_shift[ph]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Alternate stretches of back-to-back traffic with gappy ones.
                if (n % 50 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                send_probe(next_probe(), 1'b0, none);
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                else
                    idle_for(burst ? 0 : pick_gap());
            end
        end

        wait_drained();
        // Allow for a stray result up to one full divide after the last one.
        repeat (200) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
